/* rtl/core/first_fit_block_allocator_top_assert.svh */
// Assertion macros for the allocator top level
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_TOP_ASSERT_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_TOP_ASSERT_SVH
`define FFBA_ASSERT_IMPL(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");
`define FFBA_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

/* rtl/core/ffba_pkg.sv */
// Shared types and constants for the allocator
`timescale 1ns / 1ps
package ffba_pkg;
   localparam int MaxBlocks = 32;
   localparam int IdxW = $clog2(MaxBlocks);
   localparam int CntW = $clog2(MaxBlocks + 1);
   localparam int AW = 34;
   localparam logic [AW-1:0] HeaderBytes = 34'd16;
   localparam logic [AW-1:0] PageBytes = 34'd4096;
   localparam logic [AW-1:0] MinSplit = 34'd32;
   localparam logic [1:0] ST_OK = 2'd0;
   localparam logic [1:0] ST_NOFIT = 2'd1;
   localparam logic [1:0] ST_BADADDR = 2'd2;
   localparam logic [1:0] ST_FULL = 2'd3;
   localparam logic CMD_ALLOC = 1'b0;
   typedef struct packed {
      logic cmd;
      logic [31:0] request_size;
      logic page_align;
      logic [31:0] block_address;
   } req_type;
   typedef struct packed {
      logic [1:0] status;
      logic [31:0] payload_address;
      logic [31:0] bytes_in_use;
      logic [31:0] bytes_available;
      logic [31:0] bytes_in_blocks;
   } rsp_type;
endpackage

/* rtl/core/first_fit_block_allocator_top.sv */
// Top level: first-fit heap allocator with block table and sequencer
//  channel | ports                     | timing
//  req     | start, busy, req_payload  | taken on start && !busy && !csr_we
//  rsp     | rsp_valid, rsp_payload    | one cycle strobe, cannot stall
//  csr     | csr_we, csr_index, csr_wdata | taken at once
// During a beat the allocate walk checks the table entry by entry, a split
// or merge shifts the table one entry per cycle, and the closing tally
// reads one entry per cycle.
// A csr write rebuilds the table as at most one free block; reset empties it.
// The result strobe follows the last busy cycle; busy is low while it is up.
`timescale 1ns / 1ps
module first_fit_block_allocator_top import ffba_pkg::*; (
   input  logic clock,
   input  logic reset,
   input  logic start,
   output logic busy,
   input  req_type req_payload,
   output logic rsp_valid,
   output rsp_type rsp_payload,
   input  logic csr_we,
   input  logic csr_index,
   input  logic [31:0] csr_wdata
);
   localparam logic [3:0] S_IDLE = 4'd0, S_AWALK = 4'd1, S_AALIGN = 4'd2,
      S_ACHK = 4'd3, S_SHIFT = 4'd4, S_AWRITE = 4'd5, S_RWALK = 4'd6,
      S_MERGE = 4'd7, S_MSHIFT = 4'd8, S_TALLY = 4'd9, S_DONE = 4'd10;
   logic [3:0] state_ff, state_in;
   logic [31:0] base_ff, len_ff;
   logic [AW-1:0] hdr_ff [MaxBlocks];
   logic [AW-1:0] sz_ff [MaxBlocks];
   logic fr_ff [MaxBlocks];
   logic [CntW-1:0] cnt_ff;
   req_type req_ff;
   logic [IdxW-1:0] i_ff, k_ff;
   logic [CntW-1:0] j_ff;
   logic [CntW-1:0] t_ff;
   logic [AW-1:0] start_ff, pre_ff, suf_ff, acc_a_ff, acc_f_ff;
   logic [1:0] st_ff;
   logic [31:0] addr_ff;
   logic [1:0] shleft_ff;
   logic addr_hit_ff;
   logic [1:0] st_out;
   logic [CntW-1:0] wi;
   logic [AW-1:0] raw, pay, tot, used, pu, sz;
   logic sp, ss;
   assign wi = {1'b0, i_ff};
   assign raw = hdr_ff[i_ff];
   assign pay = raw + HeaderBytes;
   assign tot = HeaderBytes + sz_ff[i_ff];
   assign sz = {2'b0, req_ff.request_size};
   assign pu = (pay + PageBytes - 34'd1) & ~(PageBytes - 34'd1);
   assign used = start_ff + sz - raw;
   assign sp = pre_ff >= MinSplit;
   assign ss = (tot - used) >= MinSplit;
   assign busy = state_ff != S_IDLE;
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         base_ff <= 32'd0;
         len_ff <= 32'd0;
         cnt_ff <= '0;
         rsp_valid <= 1'b0;
         acc_a_ff <= '0;
         acc_f_ff <= '0;
         fr_ff[0] <= 1'b0;
      end else begin
         rsp_valid <= (state_ff == S_DONE);
         state_ff <= state_in;
         if (csr_we) begin
            logic [31:0] b, l;
            b = csr_index ? base_ff : csr_wdata;
            l = csr_index ? csr_wdata : len_ff;
            base_ff <= b;
            len_ff <= l;
            hdr_ff[0] <= {2'b0, b};
            sz_ff[0] <= {2'b0, l} - HeaderBytes;
            fr_ff[0] <= 1'b1;
            cnt_ff <= ({2'b0, l} >= HeaderBytes) ? CntW'(1) : CntW'(0);
         end else begin
            case (state_ff)
               S_IDLE: begin
                  if (start) begin
                     req_ff <= req_payload;
                     i_ff <= '0;
                     st_ff <= ST_OK;
                     addr_ff <= 32'd0;
                  end
               end
               S_AWALK: begin
                  if (req_ff.page_align) begin
                     start_ff <= pu;
                     pre_ff <= pu - pay;
                  end else begin
                     start_ff <= pay;
                     pre_ff <= '0;
                  end
               end
               S_AALIGN: begin
                  if (pre_ff != '0 && pre_ff < MinSplit) begin
                     start_ff <= start_ff + PageBytes;
                     pre_ff <= pre_ff + PageBytes;
                  end
               end
               S_ACHK: begin
                  if (used > tot || !fr_ff[i_ff]) i_ff <= i_ff + IdxW'(1);
                  else if (cnt_ff + CntW'(sp) + CntW'(ss) > CntW'(MaxBlocks))
                     st_ff <= ST_FULL;
                  else begin
                     suf_ff <= tot - used;
                     shleft_ff <= {1'b0, sp} + {1'b0, ss};
                     j_ff <= cnt_ff;
                     if (!sp) start_ff <= pay;
                  end
               end
               S_SHIFT: begin
                  hdr_ff[j_ff[IdxW-1:0]] <= hdr_ff[j_ff[IdxW-1:0] - IdxW'(1)];
                  sz_ff[j_ff[IdxW-1:0]] <= sz_ff[j_ff[IdxW-1:0] - IdxW'(1)];
                  fr_ff[j_ff[IdxW-1:0]] <= fr_ff[j_ff[IdxW-1:0] - IdxW'(1)];
                  if (j_ff == wi + CntW'(1)) begin
                     j_ff <= cnt_ff + CntW'(1);
                     cnt_ff <= cnt_ff + CntW'(1);
                     shleft_ff <= shleft_ff - 2'd1;
                     if (shleft_ff == 2'd2) i_ff <= i_ff;
                  end else j_ff <= j_ff - CntW'(1);
               end
               S_AWRITE: begin
                  addr_ff <= start_ff[31:0];
                  if (sp) begin
                     sz_ff[i_ff] <= pre_ff - HeaderBytes;
                     fr_ff[i_ff] <= 1'b1;
                     hdr_ff[i_ff + IdxW'(1)] <= start_ff - HeaderBytes;
                     sz_ff[i_ff + IdxW'(1)] <= ss ? sz : sz + suf_ff;
                     fr_ff[i_ff + IdxW'(1)] <= 1'b0;
                     if (ss) begin
                        hdr_ff[i_ff + IdxW'(2)] <= start_ff + sz;
                        sz_ff[i_ff + IdxW'(2)] <= suf_ff - HeaderBytes;
                        fr_ff[i_ff + IdxW'(2)] <= 1'b1;
                     end
                  end else begin
                     sz_ff[i_ff] <= ss ? sz : sz + suf_ff;
                     fr_ff[i_ff] <= 1'b0;
                     if (ss) begin
                        hdr_ff[i_ff + IdxW'(1)] <= start_ff + sz;
                        sz_ff[i_ff + IdxW'(1)] <= suf_ff - HeaderBytes;
                        fr_ff[i_ff + IdxW'(1)] <= 1'b1;
                     end
                  end
               end
               S_RWALK: begin
                  if (req_ff.block_address != 32'd0) begin
                     if (cnt_ff == '0) st_ff <= ST_BADADDR;
                     else if (((hdr_ff[i_ff] + HeaderBytes) & 34'hFFFFFFFF)
                           == {2'b0, req_ff.block_address}) begin
                        fr_ff[i_ff] <= 1'b1;
                        k_ff <= '0;
                     end else if (wi + CntW'(1) >= cnt_ff) st_ff <= ST_BADADDR;
                     else i_ff <= i_ff + IdxW'(1);
                  end
               end
               S_MERGE: begin
                  if ({1'b0, k_ff} + CntW'(1) < cnt_ff) begin
                     if (fr_ff[k_ff] && fr_ff[k_ff + IdxW'(1)]) begin
                        sz_ff[k_ff] <= sz_ff[k_ff] + HeaderBytes + sz_ff[k_ff + IdxW'(1)];
                        j_ff <= {1'b0, k_ff} + CntW'(1);
                     end else k_ff <= k_ff + IdxW'(1);
                  end
               end
               S_MSHIFT: begin
                  if (j_ff + CntW'(1) < cnt_ff) begin
                     hdr_ff[j_ff[IdxW-1:0]] <= hdr_ff[j_ff[IdxW-1:0] + IdxW'(1)];
                     sz_ff[j_ff[IdxW-1:0]] <= sz_ff[j_ff[IdxW-1:0] + IdxW'(1)];
                     fr_ff[j_ff[IdxW-1:0]] <= fr_ff[j_ff[IdxW-1:0] + IdxW'(1)];
                     j_ff <= j_ff + CntW'(1);
                  end else cnt_ff <= cnt_ff - CntW'(1);
               end
               S_TALLY: begin
                  if (t_ff < cnt_ff) begin
                     if (fr_ff[t_ff[IdxW-1:0]]) begin
                        acc_f_ff <= (t_ff == '0 ? '0 : acc_f_ff) + sz_ff[t_ff[IdxW-1:0]];
                        if (t_ff == '0) acc_a_ff <= '0;
                     end else begin
                        acc_a_ff <= (t_ff == '0 ? '0 : acc_a_ff) + sz_ff[t_ff[IdxW-1:0]];
                        if (t_ff == '0) acc_f_ff <= '0;
                     end
                  end else if (t_ff == '0) begin
                     acc_a_ff <= '0;
                     acc_f_ff <= '0;
                  end
               end
               default: ;
            endcase
         end
      end
   end
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: if (start && !csr_we)
            state_in = (req_payload.cmd == CMD_ALLOC) ? S_AWALK : S_RWALK;
         S_AWALK: begin
            if (req_ff.request_size == 32'd0 || cnt_ff == '0 || wi >= cnt_ff) begin
               state_in = S_TALLY;
            end
         end
         S_AALIGN: state_in = (pre_ff != '0 && pre_ff < MinSplit) ? S_AALIGN : S_ACHK;
         S_ACHK: begin
            if (used > tot || !fr_ff[i_ff])
               state_in = (wi + CntW'(1) >= cnt_ff) ? S_TALLY : S_AWALK;
            else if (cnt_ff + CntW'(sp) + CntW'(ss) > CntW'(MaxBlocks)) state_in = S_TALLY;
            else state_in = (sp || ss) ? S_SHIFT : S_AWRITE;
         end
         S_SHIFT: if (j_ff == wi + CntW'(1) && shleft_ff == 2'd1) state_in = S_AWRITE;
         S_AWRITE: state_in = S_TALLY;
         S_RWALK: begin
            if (req_ff.block_address == 32'd0 || cnt_ff == '0) state_in = S_TALLY;
            else if (((hdr_ff[i_ff] + HeaderBytes) & 34'hFFFFFFFF)
                  == {2'b0, req_ff.block_address}) state_in = S_MERGE;
            else if (wi + CntW'(1) >= cnt_ff) state_in = S_TALLY;
         end
         S_MERGE: begin
            if ({1'b0, k_ff} + CntW'(1) >= cnt_ff) state_in = S_TALLY;
            else if (fr_ff[k_ff] && fr_ff[k_ff + IdxW'(1)]) state_in = S_MSHIFT;
         end
         S_MSHIFT: if (!(j_ff + CntW'(1) < cnt_ff)) state_in = S_MERGE;
         S_TALLY: if (t_ff >= cnt_ff) state_in = S_DONE;
         S_DONE: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
      if (state_ff == S_AWALK && state_in == S_AWALK) state_in = S_AALIGN;
   end
   always_comb begin
      st_out = st_ff;
      if (req_ff.cmd == CMD_ALLOC && addr_ff == 32'd0 && st_ff == ST_OK
            && !(req_ff.request_size != 32'd0 && cnt_ff != '0 && addr_hit_ff))
         st_out = ST_NOFIT;
   end
   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE) addr_hit_ff <= 1'b0;
      else if (state_ff == S_AWRITE) addr_hit_ff <= 1'b1;
      if (state_ff == S_TALLY) t_ff <= t_ff + CntW'(1);
      else t_ff <= '0;
   end
   assign rsp_payload.status = st_out;
   assign rsp_payload.payload_address = (st_out == ST_OK) ? addr_ff : 32'd0;
   assign rsp_payload.bytes_in_use = acc_a_ff[31:0];
   assign rsp_payload.bytes_available = acc_f_ff[31:0];
   assign rsp_payload.bytes_in_blocks = acc_a_ff[31:0] + acc_f_ff[31:0];
`include "first_fit_block_allocator_top_assert.svh"
   `FFBA_ASSERT_NEXT(a_strobe_one, rsp_valid, !rsp_valid)
   `FFBA_ASSERT_IMPL(a_cnt_bound, 1'b1, cnt_ff <= CntW'(MaxBlocks))
   `FFBA_ASSERT_NEXT(a_busy_after_start, start && !busy && !csr_we, busy)
endmodule

/* test/testbench.sv */
// Self-checking testbench for the first-fit heap block allocator
`timescale 1ns / 1ps
module testbench;
   import ffba_pkg::*;

   localparam int TBL = 32;
   localparam longint LIMIT = 2000000;

   logic clock, reset, start, busy, rsp_valid, csr_we, csr_index;
   logic [31:0] csr_wdata;
   req_type req_payload;
   rsp_type rsp_payload;

   first_fit_block_allocator_top dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_payload(req_payload), .rsp_valid(rsp_valid), .rsp_payload(rsp_payload),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // shadow heap table
   logic [31:0] heap_base_q, heap_len_q;
   logic [63:0] blk_hdr [TBL];
   logic [63:0] blk_size [TBL];
   logic blk_free [TBL];
   int blk_count;

   req_type pending_beats [$];
   rsp_type expected_rsps [$];
   int fails, idle_left, n_ok, n_nofit, n_bad, n_full;
   bit no_idle;
   longint cycles;

   initial begin
      clock = 0;
      forever #6 clock = ~clock;
   end

   function automatic void rebuild_heap();
      for (int k = 0; k < TBL; k++) begin
         blk_hdr[k] = 0; blk_size[k] = 0; blk_free[k] = 0;
      end
      blk_count = 0;
      if (heap_len_q >= 32'd16) begin
         blk_hdr[0] = {32'd0, heap_base_q};
         blk_size[0] = {32'd0, heap_len_q} - 64'd16;
         blk_free[0] = 1;
         blk_count = 1;
      end
   endfunction

   function automatic void insert_blk(int pos, logic [63:0] hdr, logic [63:0] sz, logic fr);
      for (int k = blk_count; k > pos; k--) begin
         blk_hdr[k] = blk_hdr[k-1]; blk_size[k] = blk_size[k-1]; blk_free[k] = blk_free[k-1];
      end
      blk_hdr[pos] = hdr; blk_size[pos] = sz; blk_free[pos] = fr;
      blk_count++;
   endfunction

   function automatic void remove_blk(int pos);
      for (int k = pos; k + 1 < blk_count; k++) begin
         blk_hdr[k] = blk_hdr[k+1]; blk_size[k] = blk_size[k+1]; blk_free[k] = blk_free[k+1];
      end
      blk_count--;
   endfunction

   function automatic logic [1:0] first_fit(logic [63:0] sz, logic align,
                                            output logic [63:0] addr);
      logic [63:0] raw, pay, total, st, prefix, used, suffix;
      logic spre, ssuf;
      int need, pos;
      addr = 0;
      if (blk_count == 0 || sz == 0) return ST_NOFIT;
      for (int i = 0; i < blk_count; i++) begin
         if (!blk_free[i]) continue;
         raw = blk_hdr[i];
         pay = raw + 64'd16;
         total = 64'd16 + blk_size[i];
         st = pay;
         prefix = 0;
         if (align) begin
            st = ((pay + 64'd4095) / 64'd4096) * 64'd4096;
            prefix = st - 64'd16 - raw;
            while (prefix != 0 && prefix < 64'd32) begin
               st += 64'd4096;
               prefix = st - 64'd16 - raw;
            end
         end
         used = st + sz - raw;
         if (used > total) continue;
         suffix = total - used;
         spre = prefix >= 64'd32;
         ssuf = suffix >= 64'd32;
         need = int'(spre) + int'(ssuf);
         if (blk_count + need > TBL) return ST_FULL;
         pos = i;
         if (spre) begin
            blk_size[i] = prefix - 64'd16;
            blk_free[i] = 1;
            pos = i + 1;
            insert_blk(pos, st - 64'd16, sz, 0);
         end else begin
            st = pay;
            blk_size[i] = sz;
            blk_free[i] = 0;
         end
         if (ssuf) insert_blk(pos + 1, st + sz, suffix - 64'd16, 1);
         else blk_size[pos] += suffix;
         addr = st;
         return ST_OK;
      end
      return ST_NOFIT;
   endfunction

   function automatic logic [1:0] release_blk(logic [31:0] addr);
      int j, k;
      j = -1;
      if (addr == 0) return ST_OK;
      for (int i = 0; i < blk_count; i++)
         if (j < 0 && (blk_hdr[i] + 64'd16) % 64'h1_0000_0000 == {32'd0, addr}) j = i;
      if (j < 0) return ST_BADADDR;
      blk_free[j] = 1;
      k = 0;
      while (k + 1 < blk_count) begin
         if (blk_free[k] && blk_free[k+1]) begin
            blk_size[k] += 64'd16 + blk_size[k+1];
            remove_blk(k + 1);
         end else k++;
      end
      return ST_OK;
   endfunction

   function automatic rsp_type predict_rsp(req_type r);
      rsp_type o;
      logic [63:0] addr, used_b, free_b;
      addr = 0; used_b = 0; free_b = 0;
      if (r.cmd == CMD_ALLOC) o.status = first_fit({32'd0, r.request_size}, r.page_align, addr);
      else o.status = release_blk(r.block_address);
      for (int k = 0; k < blk_count; k++)
         if (blk_free[k]) free_b += blk_size[k]; else used_b += blk_size[k];
      o.payload_address = (o.status == ST_OK) ? addr[31:0] : 32'd0;
      o.bytes_in_use = used_b[31:0];
      o.bytes_available = free_b[31:0];
      o.bytes_in_blocks = 32'(used_b + free_b);
      return o;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %h want %h", what, got, want);
      fails++;
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         start <= 0;
         idle_left <= 0;
      end else begin
         if (start && !busy) begin
            expected_rsps.push_back(predict_rsp(pending_beats.pop_front()));
            if (!no_idle && $urandom_range(0, 3) == 0) idle_left <= $urandom_range(1, 6);
         end
         if (start && busy) begin
            start <= 1;
         end else if (idle_left > 0 || (start && !busy && !no_idle && $urandom_range(0, 3) == 0)) begin
            if (idle_left > 0) idle_left <= idle_left - 1;
            start <= 0;
         end else if (pending_beats.size() > (start && !busy ? 0 : 0)) begin
            start <= 1;
            req_payload <= pending_beats[0];
         end else begin
            start <= 0;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (expected_rsps.size() == 0) begin
            $display("result beat with nothing expected");
            fails++;
         end else begin
            rsp_type w;
            w = expected_rsps.pop_front();
            case (w.status)
               ST_OK: n_ok++;
               ST_NOFIT: n_nofit++;
               ST_BADADDR: n_bad++;
               default: n_full++;
            endcase
            if (rsp_payload.status != w.status)
               report_mismatch("status", rsp_payload.status, w.status);
            if (rsp_payload.payload_address != w.payload_address)
               report_mismatch("payload_address", rsp_payload.payload_address, w.payload_address);
            if (rsp_payload.bytes_in_use != w.bytes_in_use)
               report_mismatch("bytes_in_use", rsp_payload.bytes_in_use, w.bytes_in_use);
            if (rsp_payload.bytes_available != w.bytes_available)
               report_mismatch("bytes_available", rsp_payload.bytes_available, w.bytes_available);
            if (rsp_payload.bytes_in_blocks != w.bytes_in_blocks)
               report_mismatch("bytes_in_blocks", rsp_payload.bytes_in_blocks, w.bytes_in_blocks);
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("[first_fit_block_allocator_top] ERROR");
         $finish;
      end
   end

   task automatic wait_drained();
      @(posedge clock);
      while (pending_beats.size() != 0 || expected_rsps.size() != 0 || start || busy)
         @(posedge clock);
   endtask

   task automatic write_csr(logic idx, logic [31:0] val);
      @(posedge clock);
      csr_we <= 1; csr_index <= idx; csr_wdata <= val;
      if (idx) heap_len_q = val; else heap_base_q = val;
      rebuild_heap();
      @(posedge clock);
      csr_we <= 0;
   endtask

   function automatic req_type mk_beat(logic c, logic [31:0] sz, logic al, logic [31:0] a);
      req_type r;
      r.cmd = c; r.request_size = sz; r.page_align = al; r.block_address = a;
      return r;
   endfunction

   function automatic logic [31:0] pick_address();
      int k;
      if (blk_count == 0 || $urandom_range(0, 9) == 0) return $urandom;
      k = $urandom_range(0, blk_count - 1);
      for (int t = 0; t < blk_count; t++)
         if (!blk_free[(k + t) % blk_count] && $urandom_range(0, 7) != 0)
            return 32'(blk_hdr[(k + t) % blk_count] + 64'd16);
      return 32'(blk_hdr[k] + 64'd16);
   endfunction

   function automatic logic [31:0] pick_size();
      case ($urandom_range(0, 9))
         0: return $urandom;
         1: return 32'($urandom_range(0, 40));
         default: return 32'($urandom_range(1, 3000));
      endcase
   endfunction

   task automatic run_random(int n);
      int sent;
      sent = 0;
      while (sent < n) begin
         wait_drained();
         for (int b = 0; b < 8; b++) begin
            if ($urandom_range(0, 9) < 6)
               pending_beats.push_back(mk_beat(CMD_ALLOC, pick_size(),
                                               $urandom_range(0, 3) == 0, $urandom));
            else
               pending_beats.push_back(mk_beat(!CMD_ALLOC, $urandom, 1'($urandom_range(0, 1)),
                                               $urandom_range(0, 19) == 0 ? 32'd0 : pick_address()));
         end
         sent += 8;
      end
   endtask

   logic [31:0] bases [7] = '{32'h0000_1000, 32'h0, 32'h0, 32'h0000_0010,
                              32'hFFFF_F000, 32'hFFFF_FFFF, 32'h0001_0008};
   logic [31:0] lens [7] = '{32'h0001_0000, 32'h0, 32'd15, 32'd16,
                             32'h0002_0000, 32'hFFFF_FFFF, 32'h0000_8000};
   int rand_items [7] = '{150, 16, 16, 24, 200, 200, 300};

   initial begin
      reset = 1; start = 0; csr_we = 0; csr_index = 0; csr_wdata = 0;
      req_payload = '0; heap_base_q = 0; heap_len_q = 0;
      fails = 0; cycles = 0; no_idle = 0;
      n_ok = 0; n_nofit = 0; n_bad = 0; n_full = 0;
      rebuild_heap();
      repeat (5) @(posedge clock);
      reset <= 0;
      // no-heap behaviour straight after reset
      pending_beats.push_back(mk_beat(CMD_ALLOC, 32'd64, 1'b0, 32'd0));
      pending_beats.push_back(mk_beat(!CMD_ALLOC, 32'd0, 1'b0, 32'h0000_1010));
      pending_beats.push_back(mk_beat(!CMD_ALLOC, 32'd0, 1'b0, 32'd0));
      for (int p = 0; p < 7; p++) begin
         wait_drained();
         if (p == 6) no_idle = 1;
         write_csr(1'b0, bases[p]);
         write_csr(1'b1, lens[p]);
         if (p == 0) begin
            pending_beats.push_back(mk_beat(CMD_ALLOC, 32'd0, 1'b0, 32'd0));
            pending_beats.push_back(mk_beat(CMD_ALLOC, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF));
            pending_beats.push_back(mk_beat(CMD_ALLOC, 32'd100, 1'b1, 32'd0));
            pending_beats.push_back(mk_beat(CMD_ALLOC, 32'd1, 1'b0, 32'd0));
            pending_beats.push_back(mk_beat(CMD_ALLOC, 32'd4000, 1'b1, 32'd0));
            pending_beats.push_back(mk_beat(CMD_ALLOC, 32'h0001_0000, 1'b0, 32'd0));
            pending_beats.push_back(mk_beat(!CMD_ALLOC, 32'd0, 1'b0, 32'd0));
            pending_beats.push_back(mk_beat(!CMD_ALLOC, 32'd0, 1'b0, 32'h0000_1011));
            pending_beats.push_back(mk_beat(!CMD_ALLOC, 32'd0, 1'b0, 32'h0000_1010));
            pending_beats.push_back(mk_beat(!CMD_ALLOC, 32'd0, 1'b0, 32'h0000_1010));
            pending_beats.push_back(mk_beat(!CMD_ALLOC, 32'd0, 1'b1, 32'h0000_2000));
         end
         run_random(rand_items[p]);
      end
      wait_drained();
      repeat (20) @(posedge clock);
      $display("covered %0d heap settings, outcomes: ok %0d, no fit %0d, bad address %0d, full %0d",
               7, n_ok, n_nofit, n_bad, n_full);
      if (fails == 0) $display("[first_fit_block_allocator_top] OK");
      else $display("[first_fit_block_allocator_top] ERROR");
      $finish;
   end
endmodule

/* filelist.f */
+incdir+rtl/core
rtl/core/ffba_pkg.sv
rtl/core/first_fit_block_allocator_top.sv
test/testbench.sv
